// ===== rtl/rspc_pkg.sv =====
package rspc_pkg;

    localparam int VALUE_W = 32;
    localparam int COUNT_W = 20;
    localparam int CFG_IDX_W = 1;
    localparam int DEFAULT_MAX_ITEMS = 1024;

    localparam logic [CFG_IDX_W-1:0] CFG_BOUND_LOW = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOUND_HIGH = 1'b1;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last_item;
    } in_beat_t;

    typedef struct packed {
        logic [COUNT_W-1:0] range_count;
        logic               overflowed;
    } out_beat_t;

endpackage

// ===== rtl/rspc_ram.sv =====
module rspc_ram #(
    parameter int WIDTH = 42,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/range_sum_pair_counter.sv =====
// Counts the contiguous runs of a signed sequence whose sum lies within the
// inclusive bounds [bound_low, bound_high]. Each input beat that is taken
// has its prefix sum written to the state memory; up to MAX_ITEMS values
// are kept, later ones are dropped and flagged in the result. After the
// beat marked last_item the block stalls its input and counts: a scan of
// each stored prefix against the bounds, then ceil(log2(n)) merge passes
// that ping-pong between two memories. In each pass every segment first
// has its pairs counted, two pointers stepping through the left half for
// each right-half element, and is then merged into the other memory. Both
// memories share one read address and give registered read data, and that
// single read port sets the counting time. One result beat follows; it
// waits in an output register while the next sequence loads.
module range_sum_pair_counter #(
    parameter int MAX_ITEMS = rspc_pkg::DEFAULT_MAX_ITEMS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  rspc_pkg::in_beat_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output rspc_pkg::out_beat_t                 out_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rspc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic signed [rspc_pkg::VALUE_W-1:0] cfg_data
);

    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = AW + 2;
    localparam int SUM_W = rspc_pkg::VALUE_W + AW;
    localparam int EXT_W = SUM_W + 1;
    localparam int TW = rspc_pkg::COUNT_W + CW;
    localparam logic [TW-1:0] COUNT_MAX = TW'((1 << rspc_pkg::COUNT_W) - 1);

    localparam logic [3:0] S_LOAD     = 4'd0;
    localparam logic [3:0] S_SCAN_RD  = 4'd1;
    localparam logic [3:0] S_SCAN_CHK = 4'd2;
    localparam logic [3:0] S_PASS     = 4'd3;
    localparam logic [3:0] S_SEG      = 4'd4;
    localparam logic [3:0] S_K_RD     = 4'd5;
    localparam logic [3:0] S_K_GET    = 4'd6;
    localparam logic [3:0] S_A_RD     = 4'd7;
    localparam logic [3:0] S_A_CHK    = 4'd8;
    localparam logic [3:0] S_B_RD     = 4'd9;
    localparam logic [3:0] S_B_CHK    = 4'd10;
    localparam logic [3:0] S_ADD      = 4'd11;
    localparam logic [3:0] S_M_STEP   = 4'd12;
    localparam logic [3:0] S_M_GETL   = 4'd13;
    localparam logic [3:0] S_M_GETR   = 4'd14;
    localparam logic [3:0] S_FIN      = 4'd15;

    logic [3:0] state_reg, state_next;
    logic signed [rspc_pkg::VALUE_W-1:0] low_reg, high_reg;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [CW-1:0] n_reg, n_next;
    logic [rspc_pkg::COUNT_W-1:0] tally_reg, tally_next;
    logic drop_reg, drop_next;
    logic src_reg, src_next;
    logic [CW-1:0] width_reg, width_next;
    logic [CW-1:0] lo_reg, lo_next, mid_reg, mid_next, hi_reg, hi_next;
    logic [CW-1:0] k_reg, k_next, a_reg, a_next, b_reg, b_next;
    logic [CW-1:0] left_reg, left_next, right_reg, right_next, m_reg, m_next;
    logic signed [SUM_W-1:0] pk_reg, pk_next, pl_reg, pl_next, pr_reg, pr_next;
    logic lv_reg, lv_next, rv_reg, rv_next;
    logic out_valid_reg, out_valid_next;
    rspc_pkg::out_beat_t out_reg, out_next;

    logic [AW-1:0] rd_addr, wr_addr;
    logic [SUM_W-1:0] wr_data, rdata0, rdata1;
    logic we0, we1;
    logic signed [SUM_W-1:0] rd_val, sum_add;
    logic signed [EXT_W-1:0] rd_ext, pk_ext, low_ext, high_ext;
    logic [CW-1:0] lo_w, rest;
    logic [TW-1:0] tally_sum;
    logic in_take;

    assign cfg_ready = 1'b1;
    assign in_stall = (state_reg != S_LOAD);
    assign in_take = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data = out_reg;

    assign rd_val = $signed(src_reg ? rdata1 : rdata0);
    assign rd_ext = EXT_W'(rd_val);
    assign pk_ext = EXT_W'(pk_reg);
    assign low_ext = EXT_W'(low_reg);
    assign high_ext = EXT_W'(high_reg);
    assign sum_add = sum_reg + SUM_W'(in_data.value);
    assign lo_w = lo_reg + width_reg;
    assign rest = n_reg - lo_w;

    rspc_ram #(.WIDTH(SUM_W), .DEPTH(MAX_ITEMS)) u_mem0 (
        .clk   (clk),
        .we    (we0),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (rdata0)
    );

    rspc_ram #(.WIDTH(SUM_W), .DEPTH(MAX_ITEMS)) u_mem1 (
        .clk   (clk),
        .we    (we1),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (rdata1)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg <= '0;
            high_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                rspc_pkg::CFG_BOUND_LOW:  low_reg <= cfg_data;
                rspc_pkg::CFG_BOUND_HIGH: high_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        sum_next = sum_reg;
        n_next = n_reg;
        tally_next = tally_reg;
        drop_next = drop_reg;
        src_next = src_reg;
        width_next = width_reg;
        lo_next = lo_reg;
        mid_next = mid_reg;
        hi_next = hi_reg;
        k_next = k_reg;
        a_next = a_reg;
        b_next = b_reg;
        left_next = left_reg;
        right_next = right_reg;
        m_next = m_reg;
        pk_next = pk_reg;
        pl_next = pl_reg;
        pr_next = pr_reg;
        lv_next = lv_reg;
        rv_next = rv_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_next = out_reg;
        rd_addr = k_reg[AW-1:0];
        wr_addr = m_reg[AW-1:0];
        wr_data = pl_reg;
        we0 = 1'b0;
        we1 = 1'b0;
        tally_sum = TW'(tally_reg);

        unique case (state_reg)
            S_LOAD:
            begin
                if (in_take)
                begin
                    if (n_reg < CW'(MAX_ITEMS))
                    begin
                        wr_addr = n_reg[AW-1:0];
                        wr_data = sum_add;
                        we0 = 1'b1;
                        sum_next = sum_add;
                        n_next = n_reg + 1'b1;
                    end
                    else
                    begin
                        drop_next = 1'b1;
                    end
                    if (in_data.last_item)
                    begin
                        k_next = '0;
                        src_next = 1'b0;
                        state_next = S_SCAN_RD;
                    end
                end
            end
            S_SCAN_RD:
            begin
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                if (low_ext <= rd_ext && rd_ext <= high_ext)
                begin
                    tally_sum = TW'(tally_reg) + TW'(1);
                    tally_next = (tally_sum > COUNT_MAX) ? COUNT_MAX[rspc_pkg::COUNT_W-1:0]
                                                         : tally_sum[rspc_pkg::COUNT_W-1:0];
                end
                k_next = k_reg + 1'b1;
                if (k_reg + 1'b1 >= n_reg)
                begin
                    width_next = CW'(1);
                    state_next = S_PASS;
                end
                else
                begin
                    state_next = S_SCAN_RD;
                end
            end
            S_PASS:
            begin
                lo_next = '0;
                state_next = (width_reg >= n_reg) ? S_FIN : S_SEG;
            end
            S_SEG:
            begin
                if (lo_reg >= n_reg)
                begin
                    width_next = width_reg << 1;
                    src_next = !src_reg;
                    state_next = S_PASS;
                end
                else
                begin
                    if (lo_w >= n_reg)
                    begin
                        mid_next = n_reg;
                        hi_next = n_reg;
                    end
                    else
                    begin
                        mid_next = lo_w;
                        hi_next = (rest > width_reg) ? lo_w + width_reg : n_reg;
                    end
                    k_next = (lo_w >= n_reg) ? n_reg : lo_w;
                    a_next = lo_reg;
                    b_next = lo_reg;
                    state_next = S_K_RD;
                end
            end
            S_K_RD:
            begin
                if (k_reg >= hi_reg)
                begin
                    left_next = lo_reg;
                    right_next = mid_reg;
                    m_next = lo_reg;
                    lv_next = 1'b0;
                    rv_next = 1'b0;
                    state_next = S_M_STEP;
                end
                else
                begin
                    state_next = S_K_GET;
                end
            end
            S_K_GET:
            begin
                pk_next = rd_val;
                state_next = S_A_RD;
            end
            S_A_RD:
            begin
                rd_addr = a_reg[AW-1:0];
                state_next = (a_reg < mid_reg) ? S_A_CHK : S_B_RD;
            end
            S_A_CHK:
            begin
                if (rd_ext + low_ext <= pk_ext)
                begin
                    a_next = a_reg + 1'b1;
                    state_next = S_A_RD;
                end
                else
                begin
                    state_next = S_B_RD;
                end
            end
            S_B_RD:
            begin
                rd_addr = b_reg[AW-1:0];
                state_next = (b_reg < mid_reg) ? S_B_CHK : S_ADD;
            end
            S_B_CHK:
            begin
                if (pk_ext > rd_ext + high_ext)
                begin
                    b_next = b_reg + 1'b1;
                    state_next = S_B_RD;
                end
                else
                begin
                    state_next = S_ADD;
                end
            end
            S_ADD:
            begin
                if (a_reg > b_reg)
                begin
                    tally_sum = TW'(tally_reg) + TW'(a_reg - b_reg);
                    tally_next = (tally_sum > COUNT_MAX) ? COUNT_MAX[rspc_pkg::COUNT_W-1:0]
                                                         : tally_sum[rspc_pkg::COUNT_W-1:0];
                end
                k_next = k_reg + 1'b1;
                state_next = S_K_RD;
            end
            S_M_STEP:
            begin
                if (m_reg >= hi_reg)
                begin
                    lo_next = hi_reg;
                    state_next = S_SEG;
                end
                else if (left_reg < mid_reg && !lv_reg)
                begin
                    rd_addr = left_reg[AW-1:0];
                    state_next = S_M_GETL;
                end
                else if (right_reg < hi_reg && !rv_reg)
                begin
                    rd_addr = right_reg[AW-1:0];
                    state_next = S_M_GETR;
                end
                else
                begin
                    we0 = src_reg;
                    we1 = !src_reg;
                    if (left_reg >= mid_reg
                        || (right_reg < hi_reg && pr_reg < pl_reg))
                    begin
                        wr_data = pr_reg;
                        right_next = right_reg + 1'b1;
                        rv_next = 1'b0;
                    end
                    else
                    begin
                        wr_data = pl_reg;
                        left_next = left_reg + 1'b1;
                        lv_next = 1'b0;
                    end
                    m_next = m_reg + 1'b1;
                end
            end
            S_M_GETL:
            begin
                pl_next = rd_val;
                lv_next = 1'b1;
                state_next = S_M_STEP;
            end
            S_M_GETR:
            begin
                pr_next = rd_val;
                rv_next = 1'b1;
                state_next = S_M_STEP;
            end
            S_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_next.range_count = tally_reg;
                    out_next.overflowed = drop_reg;
                    sum_next = '0;
                    n_next = '0;
                    tally_next = '0;
                    drop_next = 1'b0;
                    state_next = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            sum_reg <= '0;
            n_reg <= '0;
            tally_reg <= '0;
            drop_reg <= 1'b0;
            src_reg <= 1'b0;
            lv_reg <= 1'b0;
            rv_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sum_reg <= sum_next;
            n_reg <= n_next;
            tally_reg <= tally_next;
            drop_reg <= drop_next;
            src_reg <= src_next;
            lv_reg <= lv_next;
            rv_reg <= rv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        width_reg <= width_next;
        lo_reg <= lo_next;
        mid_reg <= mid_next;
        hi_reg <= hi_next;
        k_reg <= k_next;
        a_reg <= a_next;
        b_reg <= b_next;
        left_reg <= left_next;
        right_reg <= right_next;
        m_reg <= m_next;
        pk_reg <= pk_next;
        pl_reg <= pl_next;
        pr_reg <= pr_next;
        out_reg <= out_next;
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= CW'(MAX_ITEMS))
        else $error("fill count beyond capacity");

    a_left_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_A_CHK) |-> (a_reg < mid_reg))
        else $error("left pointer checked past its half");

    a_merge_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_M_STEP) |-> (left_reg <= mid_reg && right_reg <= hi_reg
                                     && m_reg <= hi_reg))
        else $error("merge pointer out of its segment");

    a_out_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_stall && state_reg != S_FIN) |=> !out_valid_reg)
        else $error("result beat repeated");

    a_result_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && state_next == S_LOAD) |=> (n_reg == '0 && !drop_reg))
        else $error("sequence state not cleared after result");

endmodule

// ===== bench/tb_range_sum_pair_counter.sv =====
`timescale 1ns / 1ps

module tb_range_sum_pair_counter;

    localparam int CAPACITY = rspc_pkg::DEFAULT_MAX_ITEMS;
    localparam int CYCLE_LIMIT = 3000000;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    rspc_pkg::in_beat_t in_data;
    logic out_valid;
    logic out_stall;
    rspc_pkg::out_beat_t out_data;
    logic cfg_valid;
    logic cfg_ready;
    logic [rspc_pkg::CFG_IDX_W-1:0] cfg_index;
    logic signed [rspc_pkg::VALUE_W-1:0] cfg_data;

    range_sum_pair_counter dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    rspc_pkg::in_beat_t beat_q[$];
    rspc_pkg::out_beat_t expected_counts[$];

    longint prefix_mem[0:CAPACITY-1];
    longint run_sum;
    int seq_len;
    logic seq_drop;
    longint bound_lo;
    longint bound_hi;

    int send_idle_pct;
    int recv_idle_pct;
    logic input_hold;
    int hold_req;
    int hold_seen;
    int hold_left;
    logic in_taken;
    int errors;
    int cycles;

    initial clk = 1'b0;
    always #6 clk = ~clk;

    function automatic logic [rspc_pkg::COUNT_W-1:0] count_runs(input int n, input longint lo,
                                                                input longint hi);
        longint c;
        longint d;
        c = 0;
        for (int k = 0; k < n; k++)
        begin
            if (lo <= prefix_mem[k] && prefix_mem[k] <= hi)
                c++;
            for (int i = 0; i < k; i++)
            begin
                d = prefix_mem[k] - prefix_mem[i];
                if (lo <= d && d <= hi)
                    c++;
            end
        end
        if (c > 64'hFFFFF)
            c = 64'hFFFFF;
        return c[rspc_pkg::COUNT_W-1:0];
    endfunction

    // driver
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_taken)
        begin
            if (beat_q.size() > 0 && !input_hold && $urandom_range(0, 99) >= send_idle_pct)
            begin
                in_valid <= 1'b1;
                in_data <= beat_q.pop_front();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver
    always @(negedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_seen = hold_req;
            hold_left = 2500;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    // monitor and predictor
    always @(posedge clk)
    begin
        rspc_pkg::out_beat_t want;
        longint v;
        in_taken <= rst_n && in_valid && !in_stall;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == rspc_pkg::CFG_BOUND_LOW)
                    bound_lo = longint'(cfg_data);
                else
                    bound_hi = longint'(cfg_data);
            end
            if (in_valid && !in_stall)
            begin
                v = longint'($signed(in_data.value));
                if (seq_len < CAPACITY)
                begin
                    run_sum += v;
                    prefix_mem[seq_len] = run_sum;
                    seq_len++;
                end
                else
                    seq_drop = 1'b1;
                if (in_data.last_item)
                begin
                    want.range_count = count_runs(seq_len, bound_lo, bound_hi);
                    want.overflowed = seq_drop;
                    expected_counts.insert(expected_counts.size(), want);
                    run_sum = 0;
                    seq_len = 0;
                    seq_drop = 1'b0;
                end
            end
            if (out_valid && !out_stall)
            begin
                if (expected_counts.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected beat count=%0d ovf=%0b", $time,
                             out_data.range_count, out_data.overflowed);
                end
                else
                begin
                    want = expected_counts.pop_front();
                    if (out_data.range_count !== want.range_count)
                    begin
                        errors++;
                        $display("%0t: range_count expected %0d actual %0d", $time,
                                 want.range_count, out_data.range_count);
                    end
                    if (out_data.overflowed !== want.overflowed)
                    begin
                        errors++;
                        $display("%0t: overflowed expected %0b actual %0b", $time,
                                 want.overflowed, out_data.overflowed);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic push_beat(input longint val, input logic last);
        rspc_pkg::in_beat_t b;
        b.value = val[rspc_pkg::VALUE_W-1:0];
        b.last_item = last;
        beat_q.insert(beat_q.size(), b);
    endtask

    task automatic wait_drained();
        while (beat_q.size() > 0 || in_valid || expected_counts.size() > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(input logic [rspc_pkg::CFG_IDX_W-1:0] idx, input longint val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[rspc_pkg::VALUE_W-1:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_bounds(input longint lo, input longint hi);
        wait_drained();
        write_reg(rspc_pkg::CFG_BOUND_LOW, lo);
        write_reg(rspc_pkg::CFG_BOUND_HIGH, hi);
    endtask

    function automatic longint rand_small();
        return longint'($urandom_range(0, 40)) - 20;
    endfunction

    function automatic longint rand_full();
        return longint'($signed($urandom()));
    endfunction

    task automatic push_random_seq(input int n, input logic wide);
        for (int i = 0; i < n; i++)
            push_beat(wide ? rand_full() : rand_small(), i == n - 1);
    endtask

    initial
    begin
        longint lo;
        int budget;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = rspc_pkg::CFG_BOUND_LOW;
        cfg_data = '0;
        bound_lo = 0;
        bound_hi = 0;
        run_sum = 0;
        seq_len = 0;
        seq_drop = 1'b0;
        input_hold = 1'b0;
        hold_req = 0;
        hold_seen = 0;
        hold_left = 0;
        in_taken = 1'b0;
        errors = 0;
        cycles = 0;
        send_idle_pct = 35;
        recv_idle_pct = 88;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset bounds: zero-sum runs only
        push_beat(0, 1'b1);
        push_beat(5, 1'b0);
        push_beat(-5, 1'b0);
        push_beat(0, 1'b1);

        set_bounds(-5, 5);
        push_beat(32'h7FFFFFFF, 1'b0);
        push_beat(-32'sh80000000, 1'b0);
        push_beat(-1, 1'b0);
        push_beat(1, 1'b1);

        set_bounds(-32'sh80000000, 32'h7FFFFFFF);
        push_beat(32'h7FFFFFFF, 1'b0);
        push_beat(32'h7FFFFFFF, 1'b0);
        push_beat(-32'sh80000000, 1'b0);
        push_beat(-32'sh80000000, 1'b0);
        push_beat(-32'sh80000000, 1'b1);

        // inverted bounds
        set_bounds(10, -10);
        push_beat(0, 1'b0);
        push_beat(0, 1'b0);
        push_beat(0, 1'b1);

        set_bounds(32'h7FFFFFFF, 32'h7FFFFFFF);
        push_beat(32'h7FFFFFFF, 1'b0);
        push_beat(32'h7FFFFFFF, 1'b1);

        set_bounds(-32'sh80000000, -32'sh80000000);
        push_beat(-32'sh80000000, 1'b0);
        push_beat(-1, 1'b0);
        push_beat(-32'sh7FFFFFFF, 1'b1);

        for (int ph = 0; ph < 12; ph++)
        begin
            if (ph == 4)
            begin
                send_idle_pct = 88;
                recv_idle_pct = 35;
            end
            if (ph == 8)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            lo = rand_small();
            set_bounds(lo, lo + longint'($urandom_range(0, 30)) - 5);
            if (ph == 9)
            begin
                // overflow: last beat lands beyond capacity
                push_random_seq(CAPACITY + 2, 1'b1);
                continue;
            end
            if (ph == 10)
                hold_req++;
            budget = 8;
            while (budget > 0)
            begin
                int n;
                n = $urandom_range(1, 6);
                push_random_seq(n, $urandom_range(0, 3) == 0);
                budget -= n;
            end
        end

        set_bounds(-32'sh80000000, 32'h7FFFFFFF);
        push_random_seq(8, 1'b1);
        push_random_seq(3, 1'b0);

        wait_drained();
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
